### src/dcb_pkg.sv
// ----------------------------------------------------------------------------
// dcb_pkg
// shared types, constants and the divide-by-255 helper for the depth blend unit
// ----------------------------------------------------------------------------
`default_nettype none

package dcb_pkg;

    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 4 * CHAN_W;
    localparam int PROD_W    = 2 * CHAN_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int DEPTH_W   = 24;
    localparam int INDEX_W   = 16;

    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
    localparam logic [SUM_W-1:0]  BLEND_ROUND = 17'd127;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_BLEND
    } dcb_state_t;

    // exact x / 255 for x below 65280 via reciprocal shift and correction
    function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, x} + (SUM_W+1)'(1) + (SUM_W+1)'(x >> 8);
        return t[CHAN_W +: CHAN_W];
    endfunction

endpackage

`default_nettype wire

### src/dcb_ram.sv
// ----------------------------------------------------------------------------
// dcb_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dcb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/dcb_blend.sv
// ----------------------------------------------------------------------------
// dcb_blend
// four channel alpha blend, products registered, sum and divide after
// ----------------------------------------------------------------------------
`default_nettype none

module dcb_blend (
    input  wire logic                          clk,
    input  wire logic                          load,
    input  wire logic [dcb_pkg::COLOR_W-1:0]   stored,
    input  wire logic [dcb_pkg::COLOR_W-1:0]   incoming,
    input  wire logic [dcb_pkg::CHAN_W-1:0]    alpha,
    output      logic [dcb_pkg::COLOR_W-1:0]   blended
);

    import dcb_pkg::*;

    logic [PROD_W-1:0] prod_s_reg [4];
    logic [PROD_W-1:0] prod_v_reg [4];

    // one 8x8 product pair per channel
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_s_reg[k] <= stored[k*CHAN_W +: CHAN_W] * (CHAN_MAX - alpha);
                prod_v_reg[k] <= incoming[k*CHAN_W +: CHAN_W] * alpha;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            blended[k*CHAN_W +: CHAN_W] = div255(SUM_W'(prod_s_reg[k]) +
                SUM_W'(prod_v_reg[k]) + BLEND_ROUND);
        end
    end

endmodule

`default_nettype wire

### src/depth_composite_blend_unit.sv
// ----------------------------------------------------------------------------
// depth_composite_blend_unit
// z-buffer compositing of pixel items into a depth and color frame store
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                  payload
// pixel     in         pixel_valid / pixel_ready  pixel_index first_image in_depth in_rgba
// result    out        result_valid/result_ready  out_index out_depth out_rgba replaced
// cfg       in         cfg_valid / cfg_ready      cfg_data (alpha_mode)
//
// from acceptance to a loaded result an item passes the registered frame
// store read, then the depth compare and the blend products, then the
// divide, write back and output load
// the item register and the store read-modify-write allow one item in flight,
// so a new item is taken only after the last one has been written back
// a full result register that is not taken holds the write back stage
// reset clears the sequencer, the result valid and alpha_mode; the frame
// store is not cleared and needs no clearing pass
//
`default_nettype none

module depth_composite_blend_unit #(
    parameter int PIXEL_COUNT = 65536,
    parameter int DEPTH_BITS  = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic                          cfg_data,
    // pixel items
    input  wire logic                          pixel_valid,
    output      logic                          pixel_ready,
    input  wire logic [dcb_pkg::INDEX_W-1:0]   pixel_index,
    input  wire logic                          first_image,
    input  wire logic [dcb_pkg::DEPTH_W-1:0]   in_depth,
    input  wire logic [dcb_pkg::CHAN_W-1:0]    in_red,
    input  wire logic [dcb_pkg::CHAN_W-1:0]    in_green,
    input  wire logic [dcb_pkg::CHAN_W-1:0]    in_blue,
    input  wire logic [dcb_pkg::CHAN_W-1:0]    in_alpha,
    // result items
    output      logic                          result_valid,
    input  wire logic                          result_ready,
    output      logic [dcb_pkg::INDEX_W-1:0]   out_index,
    output      logic [dcb_pkg::DEPTH_W-1:0]   out_depth,
    output      logic [dcb_pkg::CHAN_W-1:0]    out_red,
    output      logic [dcb_pkg::CHAN_W-1:0]    out_green,
    output      logic [dcb_pkg::CHAN_W-1:0]    out_blue,
    output      logic [dcb_pkg::CHAN_W-1:0]    out_alpha,
    output      logic                          replaced
);

    import dcb_pkg::*;

    // the index port is 16 bits, so the store never needs more entries
    localparam int MEM_DEPTH = (PIXEL_COUNT > (1 << INDEX_W)) ? (1 << INDEX_W) : PIXEL_COUNT;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int EXT_W     = (DEPTH_BITS > DEPTH_W) ? DEPTH_BITS : DEPTH_W;

    dcb_state_t state_reg, state_next;

    logic                   alpha_mode_reg;

    // item registers
    logic [INDEX_W-1:0]     idx_reg;
    logic                   first_reg;
    logic [DEPTH_BITS-1:0]  depth_reg;
    logic [COLOR_W-1:0]     color_reg;
    logic                   in_range_reg;
    logic                   pass_reg;

    // result registers
    logic                   result_valid_reg;
    logic [INDEX_W-1:0]     out_index_reg;
    logic [DEPTH_W-1:0]     out_depth_reg;
    logic [COLOR_W-1:0]     out_color_reg;
    logic                   replaced_reg;

    logic                   accept;
    logic                   read_en;
    logic                   commit;
    logic                   store_we;
    logic [DEPTH_BITS-1:0]  depth_in_cut;
    logic [DEPTH_BITS-1:0]  depth_rdata;
    logic [COLOR_W-1:0]     color_rdata;
    logic [COLOR_W-1:0]     blended;
    logic [COLOR_W-1:0]     new_color;
    logic [COLOR_W-1:0]     res_color;
    logic [DEPTH_BITS-1:0]  res_depth_cut;
    logic [EXT_W-1:0]       in_depth_wide;
    logic [EXT_W-1:0]       res_depth_wide;
    logic                   in_range;

    assign cfg_ready   = 1'b1;
    assign pixel_ready = (state_reg == ST_IDLE);
    assign accept      = pixel_valid && pixel_ready;

    // only the low DEPTH_BITS of the depth take part
    assign in_depth_wide = EXT_W'(in_depth);
    assign depth_in_cut  = in_depth_wide[DEPTH_BITS-1:0];
    assign in_range      = (25'(pixel_index) < 25'(PIXEL_COUNT));

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            alpha_mode_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        read_en    = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    read_en    = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                // wait for a free result slot before the write back
                if (!result_valid_reg || result_ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // item capture and depth test
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg      <= pixel_index;
            first_reg    <= first_image;
            depth_reg    <= depth_in_cut;
            color_reg    <= {in_alpha, in_blue, in_green, in_red};
            in_range_reg <= in_range;
        end
        if (state_reg == ST_READ)
        begin
            pass_reg <= first_reg || (depth_reg <= depth_rdata);
        end
    end

    // ------------------------------------------------------------------
    // frame store
    // ------------------------------------------------------------------
    assign store_we = commit && in_range_reg && pass_reg;

    dcb_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_depth_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (idx_reg[ADDR_W-1:0]),
        .wdata (depth_reg),
        .re    (read_en),
        .raddr (pixel_index[ADDR_W-1:0]),
        .rdata (depth_rdata)
    );

    dcb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MEM_DEPTH)
    ) u_color_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (idx_reg[ADDR_W-1:0]),
        .wdata (new_color),
        .re    (read_en),
        .raddr (pixel_index[ADDR_W-1:0]),
        .rdata (color_rdata)
    );

    // products load while the store data is first valid
    dcb_blend u_blend (
        .clk      (clk),
        .load     (state_reg == ST_READ),
        .stored   (color_rdata),
        .incoming (color_reg),
        .alpha    (color_reg[3*CHAN_W +: CHAN_W]),
        .blended  (blended)
    );

    // ------------------------------------------------------------------
    // update selection
    // ------------------------------------------------------------------
    always_comb
    begin
        if (!alpha_mode_reg)
        begin
            // rgb copy drops the alpha
            new_color = {{CHAN_W{1'b0}}, color_reg[3*CHAN_W-1:0]};
        end
        else if (first_reg)
        begin
            new_color = color_reg;
        end
        else
        begin
            new_color = blended;
        end
    end

    assign res_color      = pass_reg ? new_color : color_rdata;
    assign res_depth_cut  = pass_reg ? depth_reg : depth_rdata;
    assign res_depth_wide = EXT_W'(res_depth_cut);

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_index_reg <= idx_reg;
            if (in_range_reg)
            begin
                out_depth_reg <= res_depth_wide[DEPTH_W-1:0];
                out_color_reg <= alpha_mode_reg ? res_color :
                                 {{CHAN_W{1'b0}}, res_color[3*CHAN_W-1:0]};
                replaced_reg  <= pass_reg;
            end
            else
            begin
                // index beyond the frame leaves the store alone
                out_depth_reg <= '0;
                out_color_reg <= '0;
                replaced_reg  <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign out_index    = out_index_reg;
    assign out_depth    = out_depth_reg;
    assign out_red      = out_color_reg[0*CHAN_W +: CHAN_W];
    assign out_green    = out_color_reg[1*CHAN_W +: CHAN_W];
    assign out_blue     = out_color_reg[2*CHAN_W +: CHAN_W];
    assign out_alpha    = out_color_reg[3*CHAN_W +: CHAN_W];
    assign replaced     = replaced_reg;

endmodule

`default_nettype wire

### src/dcb_checker.sv
// ----------------------------------------------------------------------------
// dcb_checker
// port level checks of the depth blend unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module dcb_checker #(
    parameter int PIXEL_COUNT = 65536
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          pixel_valid,
    input wire logic                          pixel_ready,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic [dcb_pkg::INDEX_W-1:0]   out_index,
    input wire logic [dcb_pkg::DEPTH_W-1:0]   out_depth,
    input wire logic [dcb_pkg::CHAN_W-1:0]    out_red,
    input wire logic                          replaced
);

    // a pending result stays until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result item dropped before acceptance");

    // one item in flight: pixel_ready stays low in ST_READ and on entry to ST_BLEND
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready ##1 !pixel_ready)
        else $error("pixel item taken while another is in flight");

    // an item taken while the result slot is empty shows up once ST_READ and ST_BLEND have passed
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && !result_valid |-> ##3 result_valid)
        else $error("result item missing after fixed latency");

    // an index beyond the frame reports an empty result
    a_out_of_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (25'(out_index) >= 25'(PIXEL_COUNT)) |->
            !replaced && (out_depth == '0) && (out_red == '0))
        else $error("out of frame item reported stored data");

endmodule

bind depth_composite_blend_unit dcb_checker #(
    .PIXEL_COUNT (PIXEL_COUNT)
) u_dcb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_index    (out_index),
    .out_depth    (out_depth),
    .out_red      (out_red),
    .replaced     (replaced)
);

`default_nettype wire
